@@ sv/tfd_pkg.sv @@
`timescale 1ns / 1ps
package tfd_pkg;
    typedef enum logic [2:0] {
        MODE_HALF    = 3'd0,
        MODE_R11G11B10 = 3'd1,
        MODE_B5G6R5  = 3'd2,
        MODE_BGRA8   = 3'd3,
        MODE_BGRX8   = 3'd4,
        MODE_RGBA8   = 3'd5
    } t_mode;

    localparam int NUM_LANES = 4;
    localparam logic [31:0] FLOAT_ONE  = 32'h3F800000;
    localparam logic [31:0] FLOAT_INF  = 32'h7F800000;
    localparam logic [31:0] FLOAT_QNAN = 32'h7FC00000;
    localparam logic [7:0]  EXP_ADJ    = 8'd112;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] alpha;
        logic [2:0]  count;
        logic        last;
    } t_result;

    // position of the leading one in a 10-bit mantissa (9..0)
    function automatic logic [3:0] lead_pos(input logic [9:0] m);
        logic [3:0] p;
        p = 4'd0;
        for (int k = 0; k < 10; k++) begin
            if (m[k]) p = 4'(k);
        end
        return p;
    endfunction
endpackage

@@ sv/texel_format_decoder.sv @@
`timescale 1ns / 1ps
// Unpacks one packed texel per cycle, while the output is ready, into four 32-bit
// channels. Results pass through a single output register stage; with the output ready the block
// sustains one transaction per clock, and it keeps taking input while a result
// waits as long as the stage frees in the same cycle. Four conversion lanes run
// in parallel, one per channel, and a merge stage picks the format's outputs.
module texel_format_decoder
    import tfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // pixel_word
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // chan_red, chan_green, chan_blue, chan_alpha, channel_count
    output logic         m_axis_tlast
);
    logic [2:0]  r_mode;
    logic        r_valid;
    t_result     r_res;
    t_result     n_res;
    logic [31:0] half_f  [NUM_LANES];
    logic [31:0] small_f [NUM_LANES];
    logic [10:0] small_in [NUM_LANES];

    assign small_in[0] = s_axis_tdata[10:0];
    assign small_in[1] = s_axis_tdata[21:11];
    assign small_in[2] = {1'b0, s_axis_tdata[31:22]};
    assign small_in[3] = 11'd0;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        tfd_lane u_lane (
            .i_half    (s_axis_tdata[16*l +: 16]),
            .i_small   (small_in[l]),
            .i_is_b10  (l == 2),
            .o_half_f  (half_f[l]),
            .o_small_f (small_f[l])
        );
    end

    tfd_merge u_merge (
        .i_mode    (r_mode),
        .i_word    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_half_f  (half_f),
        .i_small_f (small_f),
        .o_res     (n_res)
    );

    assign s_axis_tready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            if (s_axis_tready) r_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) r_res <= n_res;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_res.count, r_res.alpha, r_res.blue, r_res.green, r_res.red};
    assign m_axis_tlast  = r_res.last;
endmodule

@@ sv/tfd_lane.sv @@
`timescale 1ns / 1ps
module tfd_lane
    import tfd_pkg::*;
(
    input  logic [15:0] i_half,
    input  logic [10:0] i_small,
    input  logic        i_is_b10,
    output logic [31:0] o_half_f,
    output logic [31:0] o_small_f
);
    logic        h_sign;
    logic [4:0]  h_exp;
    logic [9:0]  h_man;
    logic [3:0]  h_lp;
    logic [3:0]  h_sh;
    logic [9:0]  h_norm;
    logic [4:0]  s_exp;
    logic [9:0]  s_man;
    logic [3:0]  s_lp;
    logic [3:0]  s_sh;
    logic [9:0]  s_norm;
    logic [3:0]  s_top;

    always_comb begin
        h_sign = i_half[15];
        h_exp  = i_half[14:10];
        h_man  = i_half[9:0];
        h_lp   = lead_pos(h_man);
        h_sh   = 4'd10 - h_lp;
        h_norm = h_man << h_sh;
        if (h_exp == 5'd31) begin
            o_half_f = {h_sign, FLOAT_INF[30:0]} | {9'd0, h_man, 13'd0};
        end else if (h_exp == 5'd0) begin
            if (h_man == 10'd0) begin
                o_half_f = {h_sign, 31'd0};
            end else begin
                o_half_f = {h_sign, 8'(8'd113 - {4'd0, h_sh}), h_norm, 13'd0};
            end
        end else begin
            o_half_f = {h_sign, 8'({3'd0, h_exp} + EXP_ADJ), h_man, 13'd0};
        end

        // mantissa left-aligned in [9:4] (6 bits), or in [8:4] (5 bits) for the 10-bit channel
        if (i_is_b10) begin
            s_exp = i_small[9:5];
            s_man = {1'b0, i_small[4:0], 4'd0};
        end else begin
            s_exp = i_small[10:6];
            s_man = {i_small[5:0], 4'd0};
        end
        s_top  = i_is_b10 ? 4'd8 : 4'd9;
        s_lp   = lead_pos(s_man);
        s_sh   = s_top - s_lp + 4'd1;
        s_norm = s_man << s_sh;
        if (i_is_b10) s_norm = s_norm << 1;
        if (s_exp == 5'd31) begin
            o_small_f = (s_man == 10'd0) ? FLOAT_INF : FLOAT_QNAN;
        end else if (s_exp == 5'd0) begin
            if (s_man == 10'd0) begin
                o_small_f = 32'd0;
            end else begin
                o_small_f = {1'b0, 8'(8'd113 - {4'd0, s_sh}), s_norm[9:4], 17'd0};
            end
        end else begin
            o_small_f = i_is_b10 ? {1'b0, 8'({3'd0, s_exp} + EXP_ADJ), s_man[8:4], 18'd0}
                                 : {1'b0, 8'({3'd0, s_exp} + EXP_ADJ), s_man[9:4], 17'd0};
        end
    end
endmodule

@@ sv/tfd_merge.sv @@
`timescale 1ns / 1ps
module tfd_merge
    import tfd_pkg::*;
(
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_word,
    input  logic        i_last,
    input  logic [31:0] i_half_f  [NUM_LANES],
    input  logic [31:0] i_small_f [NUM_LANES],
    output t_result     o_res
);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;

    always_comb begin
        r5 = i_word[15:11];
        g6 = i_word[10:5];
        b5 = i_word[4:0];
        o_res.last  = i_last;
        o_res.count = 3'd4;
        unique case (i_mode)
            MODE_HALF: begin
                o_res.red   = i_half_f[0];
                o_res.green = i_half_f[1];
                o_res.blue  = i_half_f[2];
                o_res.alpha = i_half_f[3];
            end
            MODE_R11G11B10: begin
                o_res.red   = i_small_f[0];
                o_res.green = i_small_f[1];
                o_res.blue  = i_small_f[2];
                o_res.alpha = FLOAT_ONE;
            end
            MODE_B5G6R5: begin
                o_res.red   = {24'd0, r5, r5[4:2]};
                o_res.green = {24'd0, g6, g6[5:4]};
                o_res.blue  = {24'd0, b5, b5[4:2]};
                o_res.alpha = 32'd0;
                o_res.count = 3'd3;
            end
            MODE_BGRA8: begin
                o_res.red   = {24'd0, i_word[23:16]};
                o_res.green = {24'd0, i_word[15:8]};
                o_res.blue  = {24'd0, i_word[7:0]};
                o_res.alpha = {24'd0, i_word[31:24]};
            end
            MODE_BGRX8: begin
                o_res.red   = {24'd0, i_word[23:16]};
                o_res.green = {24'd0, i_word[15:8]};
                o_res.blue  = {24'd0, i_word[7:0]};
                o_res.alpha = 32'd0;
                o_res.count = 3'd3;
            end
            default: begin
                o_res.red   = {24'd0, i_word[7:0]};
                o_res.green = {24'd0, i_word[15:8]};
                o_res.blue  = {24'd0, i_word[23:16]};
                o_res.alpha = {24'd0, i_word[31:24]};
            end
        endcase
    end
endmodule

@@ sv/tfd_checker.sv @@
`timescale 1ns / 1ps
module tfd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[130:128] == 3'd3 || m_axis_tdata[130:128] == 3'd4))
        else $error("bad channel count");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled with free output");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted transaction lost");
endmodule

bind texel_format_decoder tfd_checker u_tfd_checker (.*);
